@@ hdl/wfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfp_pkg
// Types and constants shared by the WebSocket frame parser modules.
// ----------------------------------------------------------------------------
package wfp_pkg;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_KEY,
      PH_PAY,
      PH_DONE
   } wfp_phase_type;

   localparam logic [6:0] LEN16_CODE = 7'd126;
   localparam logic [6:0] LEN64_CODE = 7'd127;
   localparam logic [2:0] LEN16_BYTES_M1 = 3'd1;
   localparam logic [2:0] LEN64_BYTES_M1 = 3'd7;
   localparam logic [2:0] KEY_BYTES_M1 = 3'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } wfp_req_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic       frame_end;
      logic       truncated;
      logic       fin_bit;
      logic [3:0] frame_opcode;
   } wfp_rsp_type;

   typedef struct packed {
      logic [7:0] raw_byte;
      logic [7:0] key_byte;
      logic       byte_valid;
      logic       frame_end;
      logic       truncated;
      logic       fin_bit;
      logic [3:0] frame_opcode;
   } wfp_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } wfp_queue_status_type;

endpackage

@@ hdl/wfp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfp_front
// Accepts buffer bytes, walks the frame header and emits one queue entry
// per result.
// ----------------------------------------------------------------------------
module wfp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  wfp_pkg::wfp_req_type          req_data,
   input  logic                          csr_valid,
   input  logic                          csr_wdata,
   input  wfp_pkg::wfp_queue_status_type queue_status,
   output logic                          push_valid,
   output wfp_pkg::wfp_entry_type        push_data
);

   wfp_pkg::wfp_phase_type phase_ff, phase_in, phase_step;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_flag_ff, mask_flag_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [2:0]  hdr_count_ff, hdr_count_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_pos_ff, mask_pos_in;
   logic        unmask_ff, unmask_in;

   logic        accept;
   logic [7:0]  b;
   logic [6:0]  len7;
   logic [63:0] ext_length;
   logic [7:0]  key_sel;

   assign req_stall  = queue_status.full;
   assign accept     = req_valid & ~queue_status.full;
   assign b          = req_data.in_byte;
   assign len7       = b[6:0];
   assign ext_length = {remaining_ff[55:0], b};
   assign unmask_in  = csr_valid ? csr_wdata : unmask_ff;

   always_comb begin
      case (mask_pos_ff)
         2'd0: key_sel = mask_key_ff[31:24];
         2'd1: key_sel = mask_key_ff[23:16];
         2'd2: key_sel = mask_key_ff[15:8];
         default: key_sel = mask_key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_step = phase_ff;
      unique case (phase_ff)
         wfp_pkg::PH_HDR0: phase_step = wfp_pkg::PH_HDR1;
         wfp_pkg::PH_HDR1: begin
            if (len7 == wfp_pkg::LEN16_CODE || len7 == wfp_pkg::LEN64_CODE) begin
               phase_step = wfp_pkg::PH_EXT;
            end else if (b[7]) begin
               phase_step = wfp_pkg::PH_KEY;
            end else if (len7 == 7'd0) begin
               phase_step = wfp_pkg::PH_DONE;
            end else begin
               phase_step = wfp_pkg::PH_PAY;
            end
         end
         wfp_pkg::PH_EXT: begin
            if (hdr_count_ff == 3'd0) begin
               if (mask_flag_ff) begin
                  phase_step = wfp_pkg::PH_KEY;
               end else if (ext_length == 64'd0) begin
                  phase_step = wfp_pkg::PH_DONE;
               end else begin
                  phase_step = wfp_pkg::PH_PAY;
               end
            end
         end
         wfp_pkg::PH_KEY: begin
            if (hdr_count_ff == 3'd0) begin
               phase_step = (remaining_ff == 64'd0) ? wfp_pkg::PH_DONE : wfp_pkg::PH_PAY;
            end
         end
         wfp_pkg::PH_PAY: begin
            if (remaining_ff == 64'd1) begin
               phase_step = wfp_pkg::PH_DONE;
            end
         end
         wfp_pkg::PH_DONE: phase_step = wfp_pkg::PH_DONE;
         default: phase_step = wfp_pkg::PH_HDR0;
      endcase
      phase_in = phase_ff;
      if (accept) begin
         phase_in = req_data.in_last ? wfp_pkg::PH_HDR0 : phase_step;
      end
   end

   always_comb begin
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      mask_flag_in = mask_flag_ff;
      remaining_in = remaining_ff;
      hdr_count_in = hdr_count_ff;
      mask_key_in  = mask_key_ff;
      mask_pos_in  = mask_pos_ff;
      push_valid   = 1'b0;
      push_data    = '0;
      if (accept) begin
         unique case (phase_ff)
            wfp_pkg::PH_HDR0: begin
               fin_in    = b[7];
               opcode_in = b[3:0];
            end
            wfp_pkg::PH_HDR1: begin
               mask_flag_in = b[7];
               if (len7 == wfp_pkg::LEN16_CODE) begin
                  remaining_in = 64'd0;
                  hdr_count_in = wfp_pkg::LEN16_BYTES_M1;
               end else if (len7 == wfp_pkg::LEN64_CODE) begin
                  remaining_in = 64'd0;
                  hdr_count_in = wfp_pkg::LEN64_BYTES_M1;
               end else begin
                  remaining_in = {57'd0, len7};
                  if (b[7]) begin
                     hdr_count_in = wfp_pkg::KEY_BYTES_M1;
                     mask_key_in  = 32'd0;
                  end else begin
                     mask_pos_in = 2'd0;
                     if (len7 == 7'd0) begin
                        push_valid          = 1'b1;
                        push_data.frame_end = 1'b1;
                     end
                  end
               end
            end
            wfp_pkg::PH_EXT: begin
               remaining_in = ext_length;
               if (hdr_count_ff == 3'd0) begin
                  if (mask_flag_ff) begin
                     hdr_count_in = wfp_pkg::KEY_BYTES_M1;
                     mask_key_in  = 32'd0;
                  end else begin
                     mask_pos_in = 2'd0;
                     if (ext_length == 64'd0) begin
                        push_valid          = 1'b1;
                        push_data.frame_end = 1'b1;
                     end
                  end
               end else begin
                  hdr_count_in = hdr_count_ff - 3'd1;
               end
            end
            wfp_pkg::PH_KEY: begin
               mask_key_in = {mask_key_ff[23:0], b};
               if (hdr_count_ff == 3'd0) begin
                  mask_pos_in = 2'd0;
                  if (remaining_ff == 64'd0) begin
                     push_valid          = 1'b1;
                     push_data.frame_end = 1'b1;
                  end
               end else begin
                  hdr_count_in = hdr_count_ff - 3'd1;
               end
            end
            wfp_pkg::PH_PAY: begin
               mask_pos_in          = mask_pos_ff + 2'd1;
               remaining_in         = remaining_ff - 64'd1;
               push_valid           = 1'b1;
               push_data.raw_byte   = b;
               push_data.key_byte   = (unmask_ff & mask_flag_ff) ? key_sel : 8'd0;
               push_data.byte_valid = 1'b1;
               push_data.frame_end  = (remaining_ff == 64'd1);
            end
            wfp_pkg::PH_DONE: begin
            end
            default: begin
            end
         endcase
         if (req_data.in_last) begin
            if (phase_step != wfp_pkg::PH_DONE) begin
               push_valid          = 1'b1;
               push_data.truncated = 1'b1;
            end
            hdr_count_in = 3'd0;
            mask_pos_in  = 2'd0;
         end
      end
      push_data.fin_bit      = fin_in;
      push_data.frame_opcode = opcode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wfp_pkg::PH_HDR0;
         fin_ff       <= 1'b0;
         opcode_ff    <= 4'd0;
         mask_flag_ff <= 1'b0;
         remaining_ff <= 64'd0;
         hdr_count_ff <= 3'd0;
         mask_key_ff  <= 32'd0;
         mask_pos_ff  <= 2'd0;
         unmask_ff    <= 1'b1;
      end else begin
         phase_ff     <= phase_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         mask_flag_ff <= mask_flag_in;
         remaining_ff <= remaining_in;
         hdr_count_ff <= hdr_count_in;
         mask_key_ff  <= mask_key_in;
         mask_pos_ff  <= mask_pos_in;
         unmask_ff    <= unmask_in;
      end
   end

endmodule

@@ hdl/wfp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfp_queue
// Short result queue between the header parser and the output stage.
// ----------------------------------------------------------------------------
module wfp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  wfp_pkg::wfp_entry_type        push_data,
   input  logic                          pop,
   output wfp_pkg::wfp_entry_type        head,
   output wfp_pkg::wfp_queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   wfp_pkg::wfp_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.empty = (count_ff == CNT_W'(0));
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign head         = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/wfp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfp_back
// Output stage: takes queue entries, applies the mask key and holds the
// result until the transfer completes.
// ----------------------------------------------------------------------------
module wfp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  wfp_pkg::wfp_entry_type        head,
   input  wfp_pkg::wfp_queue_status_type queue_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output wfp_pkg::wfp_rsp_type          rsp_data
);

   logic                 rsp_valid_ff, rsp_valid_in;
   wfp_pkg::wfp_rsp_type rsp_data_ff, rsp_data_in;

   assign pop = ~queue_status.empty & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.payload_byte = head.raw_byte ^ head.key_byte;
         rsp_data_in.byte_valid   = head.byte_valid;
         rsp_data_in.frame_end    = head.frame_end;
         rsp_data_in.truncated    = head.truncated;
         rsp_data_in.fin_bit      = head.fin_bit;
         rsp_data_in.frame_opcode = head.frame_opcode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/websocket_frame_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_parser
// Receive-side WebSocket frame parser, one buffer byte per transfer.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle while req_stall is low and gives
// at most one result per byte: payload bytes (unmasked when csr_wdata last
// wrote 1, the reset value), one empty frame-end result for a zero-length
// frame, or a truncation result when the buffer ends early. The header parser
// feeds a queue of QUEUE_DEPTH results that the output register drains, one
// per cycle when rsp is not stalled, so req_stall rises only when the result
// side has stalled long enough to fill that queue.
module websocket_frame_parser #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  wfp_pkg::wfp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output wfp_pkg::wfp_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_wdata
);

   logic                          push_valid;
   wfp_pkg::wfp_entry_type        push_data;
   logic                          pop;
   wfp_pkg::wfp_entry_type        head;
   wfp_pkg::wfp_queue_status_type queue_status;

   assign csr_ready = 1'b1;

   wfp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .csr_valid    (csr_valid & csr_ready),
      .csr_wdata    (csr_wdata),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   wfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   wfp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

@@ hdl/wfp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfp_checker
// Port-level assertions for the WebSocket frame parser.
// ----------------------------------------------------------------------------
module wfp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input wfp_pkg::wfp_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result changed before its transfer.");

   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.payload_byte == 8'd0)
      else $error("Result without a payload byte carries a nonzero byte.");

   a_trunc_not_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.truncated |-> !rsp_data.frame_end)
      else $error("Truncated result also marks frame end.");

   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid && !rsp_data.truncated |-> rsp_data.frame_end)
      else $error("Result with neither byte nor truncation is not a frame end.");

endmodule

bind websocket_frame_parser wfp_checker u_wfp_checker (.*);

@@ test/tb_websocket_frame_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_parser
// Self-checking bench for the receive-side WebSocket frame parser.
// ----------------------------------------------------------------------------
// A short table of hand-written buffers covers empty frames, header and
// payload truncation, trailing bytes and a 64-bit length with the top bit
// set. Random buffers follow: mostly well-formed frames with random headers,
// lengths, mask keys and payloads, plus cut-short buffers and noise. Every
// accepted byte is run through a local frame parser model, and each result
// transfer is compared field by field with the oldest parsed result. The run
// steps through idle and stall mixes on both channels and both settings of
// the unmask register.
// ----------------------------------------------------------------------------
module tb_websocket_frame_parser;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_BYTES = 36;

   typedef struct {
      wfp_pkg::wfp_req_type item;
      bit                   typed;
      wfp_pkg::wfp_rsp_type rsp;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   wfp_pkg::wfp_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   wfp_pkg::wfp_rsp_type rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic                 csr_wdata;

   bit                   row_typed;
   wfp_pkg::wfp_rsp_type row_rsp;
   int                   idle_pct;
   int                   stall_pct;
   int                   err_count = 0;
   int                   cycle_count = 0;

   wfp_pkg::wfp_rsp_type parsed_results[$];
   dir_row_type          dir_rows[$];

   // Local copy of the parser state.
   wfp_pkg::wfp_phase_type rx_phase = wfp_pkg::PH_HDR0;
   logic          rx_fin = 1'b0;
   logic [3:0]    rx_opcode = 4'h0;
   logic          rx_masked = 1'b0;
   logic [63:0]   rx_left = 64'd0;
   logic [2:0]    rx_hdr_left = 3'd0;
   logic [31:0]   rx_key = 32'd0;
   logic [1:0]    rx_key_pos = 2'd0;
   logic          unmask_on = 1'b1;

   websocket_frame_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic wfp_pkg::wfp_rsp_type rsp_of(logic [7:0] pb, logic bv, logic fe,
                                                   logic tr, logic fb, logic [3:0] op);
      wfp_pkg::wfp_rsp_type r;
      r.payload_byte = pb;
      r.byte_valid = bv;
      r.frame_end = fe;
      r.truncated = tr;
      r.fin_bit = fb;
      r.frame_opcode = op;
      return r;
   endfunction

   function automatic string rsp_str(wfp_pkg::wfp_rsp_type r);
      return $sformatf("byte=%h valid=%b end=%b trunc=%b fin=%b op=%h", r.payload_byte,
                       r.byte_valid, r.frame_end, r.truncated, r.fin_bit, r.frame_opcode);
   endfunction

   function automatic void log_error(string msg);
      err_count++;
      if (err_count <= 10) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endfunction

   function automatic bit open_payload(output wfp_pkg::wfp_rsp_type res);
      rx_key_pos = 2'd0;
      if (rx_left == 64'd0) begin
         rx_phase = wfp_pkg::PH_DONE;
         res = rsp_of(8'h00, 1'b0, 1'b1, 1'b0, rx_fin, rx_opcode);
         return 1'b1;
      end
      rx_phase = wfp_pkg::PH_PAY;
      return 1'b0;
   endfunction

   function automatic bit finish_length(output wfp_pkg::wfp_rsp_type res);
      if (rx_masked) begin
         rx_hdr_left = wfp_pkg::KEY_BYTES_M1;
         rx_key = 32'd0;
         rx_phase = wfp_pkg::PH_KEY;
         return 1'b0;
      end
      return open_payload(res);
   endfunction

   // Advances the parser state by one buffer byte and returns 1 with the
   // result in res when the byte causes one.
   function automatic bit parse_frame_byte(input wfp_pkg::wfp_req_type item,
                                           output wfp_pkg::wfp_rsp_type res);
      bit         has;
      logic [7:0] b;
      logic [6:0] len7;
      has = 1'b0;
      res = '0;
      b = item.in_byte;
      case (rx_phase)
         wfp_pkg::PH_HDR0: begin
            rx_fin = b[7];
            rx_opcode = b[3:0];
            rx_phase = wfp_pkg::PH_HDR1;
         end
         wfp_pkg::PH_HDR1: begin
            len7 = b[6:0];
            rx_masked = b[7];
            rx_left = 64'd0;
            if (len7 == wfp_pkg::LEN16_CODE) begin
               rx_hdr_left = wfp_pkg::LEN16_BYTES_M1;
               rx_phase = wfp_pkg::PH_EXT;
            end else if (len7 == wfp_pkg::LEN64_CODE) begin
               rx_hdr_left = wfp_pkg::LEN64_BYTES_M1;
               rx_phase = wfp_pkg::PH_EXT;
            end else begin
               rx_left = {57'd0, len7};
               has = finish_length(res);
            end
         end
         wfp_pkg::PH_EXT: begin
            rx_left = {rx_left[55:0], b};
            if (rx_hdr_left == 3'd0) has = finish_length(res);
            else rx_hdr_left = rx_hdr_left - 3'd1;
         end
         wfp_pkg::PH_KEY: begin
            rx_key = {rx_key[23:0], b};
            if (rx_hdr_left == 3'd0) has = open_payload(res);
            else rx_hdr_left = rx_hdr_left - 3'd1;
         end
         wfp_pkg::PH_PAY: begin
            if (unmask_on && rx_masked) begin
               b = b ^ rx_key[8 * (3 - rx_key_pos) +: 8];
            end
            rx_key_pos = rx_key_pos + 2'd1;
            rx_left = rx_left - 64'd1;
            res = rsp_of(b, 1'b1, rx_left == 64'd0, 1'b0, rx_fin, rx_opcode);
            has = 1'b1;
            if (rx_left == 64'd0) rx_phase = wfp_pkg::PH_DONE;
         end
         default: begin
         end
      endcase
      if (item.in_last) begin
         if (rx_phase != wfp_pkg::PH_DONE) begin
            if (has) begin
               res.truncated = 1'b1;
            end else begin
               res = rsp_of(8'h00, 1'b0, 1'b0, 1'b1, rx_fin, rx_opcode);
               has = 1'b1;
            end
         end
         rx_phase = wfp_pkg::PH_HDR0;
         rx_hdr_left = 3'd0;
         rx_key_pos = 2'd0;
      end
      return has;
   endfunction

   always @(posedge clock) begin : monitor
      wfp_pkg::wfp_rsp_type pred;
      wfp_pkg::wfp_rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) unmask_on = csr_wdata;
         if (req_valid && !req_stall) begin
            if (parse_frame_byte(req_data, pred)) begin
               parsed_results.insert(parsed_results.size(), row_typed ? row_rsp : pred);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (parsed_results.size() == 0) begin
               log_error($sformatf("result with none expected: %s", rsp_str(rsp_data)));
            end else begin
               want = parsed_results.pop_front();
               if (rsp_data.payload_byte !== want.payload_byte ||
                   rsp_data.byte_valid !== want.byte_valid ||
                   rsp_data.frame_end !== want.frame_end ||
                   rsp_data.truncated !== want.truncated ||
                   rsp_data.fin_bit !== want.fin_bit ||
                   rsp_data.frame_opcode !== want.frame_opcode) begin
                  log_error($sformatf("expected %s, got %s", rsp_str(want),
                                      rsp_str(rsp_data)));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   function automatic void add_row(logic [7:0] b, logic l, bit typed,
                                   wfp_pkg::wfp_rsp_type r);
      dir_row_type row;
      row.item.in_byte = b;
      row.item.in_last = l;
      row.typed = typed;
      row.rsp = r;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input wfp_pkg::wfp_req_type item, input bit typed,
                            input wfp_pkg::wfp_rsp_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      row_typed <= typed;
      row_rsp <= want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (parsed_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_unmask(input logic v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Builds one random receive buffer and sends it; counted excludes bytes
   // that trail a complete frame.
   task automatic send_buffer(output int counted);
      wfp_pkg::wfp_req_type frame_q[$];
      logic [63:0] flen;
      logic [6:0]  code;
      logic        masked;
      int          kind;
      int          pick;
      int          n_pay;
      int          n_trail;
      int          cut;
      flen = 64'd0;
      n_trail = 0;
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 6)) frame_q.insert(frame_q.size(), {8'($urandom), 1'b0});
      end else begin
         masked = 1'($urandom_range(1));
         pick = $urandom_range(99);
         if (pick < 70) begin
            flen = 64'((pick < 3) ? $urandom_range(100, 125) : $urandom_range(0, 20));
            code = flen[6:0];
         end else if (pick < 85) begin
            flen = 64'((pick < 74) ? $urandom_range(0, 65535) : $urandom_range(0, 30));
            code = wfp_pkg::LEN16_CODE;
         end else begin
            flen = (pick < 90) ? {$urandom, $urandom} : 64'($urandom_range(0, 30));
            code = wfp_pkg::LEN64_CODE;
         end
         frame_q.insert(frame_q.size(), {8'($urandom), 1'b0});
         frame_q.insert(frame_q.size(), {masked, code, 1'b0});
         if (code == wfp_pkg::LEN16_CODE) begin
            frame_q.insert(frame_q.size(), {flen[15:8], 1'b0});
            frame_q.insert(frame_q.size(), {flen[7:0], 1'b0});
         end else if (code == wfp_pkg::LEN64_CODE) begin
            for (int i = 7; i >= 0; i--) begin
               frame_q.insert(frame_q.size(), {flen[8 * i +: 8], 1'b0});
            end
         end
         if (masked) begin
            repeat (4) frame_q.insert(frame_q.size(), {8'($urandom), 1'b0});
         end
         n_pay = (flen <= 64'd125) ? int'(flen) : $urandom_range(0, 6);
         repeat (n_pay) frame_q.insert(frame_q.size(), {8'($urandom), 1'b0});
      end
      pick = $urandom_range(99);
      if (pick < 15 && frame_q.size() > 1) begin
         cut = $urandom_range(1, frame_q.size() - 1);
         while (frame_q.size() > cut) void'(frame_q.pop_back());
      end else if (pick < 30 && kind >= 10 && flen <= 64'd125) begin
         n_trail = $urandom_range(1, 3);
         repeat (n_trail) frame_q.insert(frame_q.size(), {8'($urandom), 1'b0});
      end
      frame_q[frame_q.size() - 1].in_last = 1'b1;
      foreach (frame_q[i]) send_byte(frame_q[i], 1'b0, '0);
      counted = frame_q.size() - n_trail;
   endtask

   initial begin
      int fed;
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_wdata = 1'b0;
      row_typed = 1'b0;
      row_rsp = '0;
      idle_pct = 0;
      stall_pct = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Empty frame right after reset, then a buffer cut after header byte 0.
      add_row(8'h81, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b1, 1'b1, rsp_of(8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 4'h1));
      add_row(8'hFF, 1'b1, 1'b1, rsp_of(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 4'hF));
      // Masked one-byte frame followed by a trailing byte that ends the buffer.
      add_row(8'h02, 1'b0, 1'b0, '0);
      add_row(8'h81, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'hAA, 1'b0, 1'b0, '0);
      add_row(8'h55, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b1, rsp_of(8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 4'h2));
      add_row(8'h33, 1'b1, 1'b0, '0);
      // Buffer ends inside a 16-bit extended length.
      add_row(8'h88, 1'b0, 1'b0, '0);
      add_row(8'h7E, 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b1, 1'b1, rsp_of(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 4'h8));
      // 64-bit length with the top bit set, cut on the first payload byte.
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'h7F, 1'b0, 1'b0, '0);
      add_row(8'h80, 1'b0, 1'b0, '0);
      repeat (6) add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(8'h01, 1'b0, 1'b0, '0);
      add_row(8'h5A, 1'b1, 1'b1, rsp_of(8'h5A, 1'b1, 1'b0, 1'b1, 1'b0, 4'h0));
      foreach (dir_rows[i]) send_byte(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].rsp);

      for (int p = 0; p < 8; p++) begin
         wait_drained();
         case (p % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 69;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 69;
            end
            default: begin
               idle_pct = 21;
               stall_pct = 21;
            end
         endcase
         write_unmask(!p[2]);
         fed = 0;
         while (fed < PHASE_BYTES) begin
            send_buffer(n);
            fed += n;
         end
      end
      wait_drained();

      if (err_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
